[rtl/a2p_pkg.sv]
// a2p_pkg: shared types and constants of the audio sample to pcm16 converter
// used by audio_sample_to_pcm16_unit, a2p_norm and a2p_quant; no dependencies
package a2p_pkg;

  // source sample formats held in the format register
  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5
  } fmt_e;

  localparam fmt_e FMT_RESET = FMT_S16;

  // fraction magnitude one in unsigned q0.39
  localparam logic [39:0] ONE_Q39 = 40'h80_0000_0000;

  // full scale expressed as significand and left shift (2^23 << 16)
  localparam logic [31:0] SAT_SIG   = 32'h0080_0000;
  localparam logic [5:0]  SAT_SHAMT = 6'd16;

  // sideband that travels with every transaction
  typedef struct packed {
    logic        neg;
    logic        pass;
    logic [15:0] pass_val;
  } side_t;

  // decoded sample: magnitude = round24(sig) << shamt
  typedef struct packed {
    side_t       side;
    logic [31:0] sig;
    logic [5:0]  shamt;
  } dec_t;

  // normalized fraction magnitude in q0.39
  typedef struct packed {
    side_t       side;
    logic [39:0] mag;
  } mag_t;

endpackage

[rtl/a2p_norm.sv]
// a2p_norm: rounds the decoded significand to 24 bits and aligns it to q0.39
// depends on a2p_pkg (dec_t, mag_t)
module a2p_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  a2p_pkg::dec_t in_dec_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output a2p_pkg::mag_t out_mag_o
);
  import a2p_pkg::*;

  logic        s2_vld_q, s3_vld_q;
  logic        s2_rdy, s3_rdy;
  side_t       s2_side_q;
  logic [32:0] s2_rnd_q, s2_rnd_d;
  logic [5:0]  s2_shamt_q;
  mag_t        s3_q, s3_d;

  logic [4:0]  rsh;
  logic [31:0] rmask, rlow, rhalf, rtrunc;
  logic [32:0] rstep;
  logic        rup;

  // ready chain, a stage moves when it is empty or its successor moves
  assign s3_rdy     = !s3_vld_q || !out_stall_i;
  assign s2_rdy     = !s2_vld_q || s3_rdy;
  assign in_stall_o = !s2_rdy;

  // number of bits above 24 significant ones (only s32, or a float64 rounding carry, can have them)
  always_comb begin
    rsh = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_dec_i.sig[24 + i]) begin
        rsh = 5'(i + 1);
      end
    end
  end

  // round to 24 significant bits, ties to even
  always_comb begin
    rmask    = (32'd1 << rsh) - 32'd1;
    rlow     = in_dec_i.sig & rmask;
    rhalf    = (32'd1 << rsh) >> 1;
    rtrunc   = in_dec_i.sig & ~rmask;
    rstep    = 33'd1 << rsh;
    rup      = (rsh != 5'd0) &&
               ((rlow > rhalf) || ((rlow == rhalf) && in_dec_i.sig[rsh]));
    s2_rnd_d = {1'b0, rtrunc} + (rup ? rstep : 33'd0);
  end

  // rounding stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && in_valid_i) begin
      s2_side_q  <= in_dec_i.side;
      s2_rnd_q   <= s2_rnd_d;
      s2_shamt_q <= in_dec_i.shamt;
    end
  end

  // alignment shift into q0.39
  always_comb begin
    s3_d.side = s2_side_q;
    s3_d.mag  = {7'b0, s2_rnd_q} << s2_shamt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_vld_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_vld_q;
  assign out_mag_o   = s3_q;

  // aligned magnitude never exceeds full scale
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> (s3_q.mag <= ONE_Q39))
    else $error("a2p_norm: magnitude above one");

endmodule

[rtl/a2p_quant.sv]
// a2p_quant: scales a q0.39 fraction by 32767 with single precision rounding
// and rounds to a signed 16-bit sample; depends on a2p_pkg (mag_t, side_t)
module a2p_quant (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  a2p_pkg::mag_t in_mag_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [15:0]   out_pcm_o
);
  import a2p_pkg::*;

  localparam logic [54:0] PROD_MAX = {1'b0, 15'h7FFF, 39'b0};

  logic        s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q;
  logic        s4_rdy, s5_rdy, s6_rdy, s7_rdy;
  side_t       s4_side_q, s5_side_q, s6_side_q;
  logic [54:0] s4_p_q, s4_p_d;
  logic [54:0] s5_p_q;
  logic [5:0]  s5_sh_q, s5_sh_d;
  logic [54:0] s6_p_q, s6_p_d;
  logic [15:0] s7_pcm_q, s7_pcm_d;

  logic [54:0] pmask, plow, phalf, ptrunc, pstep;
  logic        pup;
  logic [15:0] iq, in_mag;
  logic [38:0] irem;
  logic        iup;

  // ready chain from the output register back
  assign s7_rdy     = !s7_vld_q || !out_stall_i;
  assign s6_rdy     = !s6_vld_q || s7_rdy;
  assign s5_rdy     = !s5_vld_q || s6_rdy;
  assign s4_rdy     = !s4_vld_q || s5_rdy;
  assign in_stall_o = !s4_rdy;

  // product by 32767 as a shift and subtract
  assign s4_p_d = {in_mag_i.mag, 15'b0} - {15'b0, in_mag_i.mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && in_valid_i) begin
      s4_side_q <= in_mag_i.side;
      s4_p_q    <= s4_p_d;
    end
  end

  // leading one search: bits beyond 24 significant ones
  always_comb begin
    s5_sh_d = '0;
    for (int i = 0; i < 30; i++) begin
      if (s4_p_q[24 + i]) begin
        s5_sh_d = 6'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (s5_rdy) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_rdy && s4_vld_q) begin
      s5_side_q <= s4_side_q;
      s5_p_q    <= s4_p_q;
      s5_sh_q   <= s5_sh_d;
    end
  end

  // single precision rounding of the product, ties to even
  always_comb begin
    pmask  = (55'd1 << s5_sh_q) - 55'd1;
    plow   = s5_p_q & pmask;
    phalf  = (55'd1 << s5_sh_q) >> 1;
    ptrunc = s5_p_q & ~pmask;
    pstep  = 55'd1 << s5_sh_q;
    pup    = (s5_sh_q != 6'd0) &&
             ((plow > phalf) || ((plow == phalf) && s5_p_q[s5_sh_q]));
    s6_p_d = ptrunc + (pup ? pstep : 55'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (s6_rdy) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_rdy && s5_vld_q) begin
      s6_side_q <= s5_side_q;
      s6_p_q    <= s6_p_d;
    end
  end

  // integer rounding, ties to even, then sign and pass-through select
  always_comb begin
    iq     = s6_p_q[54:39];
    irem   = s6_p_q[38:0];
    iup    = irem[38] && ((irem[37:0] != 38'd0) || iq[0]);
    in_mag = iq + {15'b0, iup};
    if (s6_side_q.pass) begin
      s7_pcm_d = s6_side_q.pass_val;
    end else if (s6_side_q.neg) begin
      s7_pcm_d = 16'd0 - in_mag;
    end else begin
      s7_pcm_d = in_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (s7_rdy) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s7_rdy && s6_vld_q) begin
      s7_pcm_q <= s7_pcm_d;
    end
  end

  assign out_valid_o = s7_vld_q;
  assign out_pcm_o   = s7_pcm_q;

  // rounded product stays within 32767 full scale
  a_prod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_vld_q |-> (s6_p_q <= PROD_MAX))
    else $error("a2p_quant: rounded product above full scale");

endmodule

[rtl/audio_sample_to_pcm16_unit.sv]
// audio_sample_to_pcm16_unit: wav sample word to signed 16-bit pcm converter
// depends on a2p_pkg, a2p_norm and a2p_quant
//
// usage:
//   input channel: in_valid_i / in_stall_o carry sample_bytes_i, the
//   little-endian sample in its low bytes. a transaction is taken at an edge
//   with valid high and stall low.
//   output channel: out_valid_o / out_stall_i carry pcm_sample_o.
//   cfg_we_i writes cfg_wdata_i into the format register (u8, s16, s24,
//   s32, float32, float64); write it only while the pipe is empty.
//   stages: seven register stages; decode, significand rounding, alignment,
//   product, leading one search, product rounding and integer rounding.
//   throughput: one transaction per cycle, limited only by the handshake.
//   reset: pipe empties, format returns to s16 pass-through.
//   stall: a stalled result holds; empty stages upstream keep filling, and
//   in_stall_o rises only once every stage holds a transaction.
module audio_sample_to_pcm16_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        sample_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pcm_sample_o
);
  import a2p_pkg::*;

  localparam logic [7:0]  F32_EXP_SPECIAL = 8'hFF;
  localparam logic [7:0]  F32_EXP_ONE     = 8'd127;
  localparam logic [7:0]  F32_EXP_MIN     = 8'd111;
  localparam logic [10:0] F64_EXP_SPECIAL = 11'h7FF;
  localparam logic [10:0] F64_EXP_ONE     = 11'd1023;
  localparam logic [10:0] F64_EXP_MIN     = 11'd1007;
  localparam logic [5:0]  U8_SHAMT        = 6'd32;
  localparam logic [5:0]  S24_SHAMT       = 6'd16;
  localparam logic [5:0]  S32_SHAMT       = 6'd8;

  logic [2:0]  fmt_q;
  logic        s1_vld_q, s1_rdy;
  dec_t        s1_q, s1_d;
  logic        norm_vld, norm_stall, quant_stall;
  mag_t        norm_mag;
  logic [15:0] pcm;

  logic [7:0]  u8_byte, u8_mag;
  logic [23:0] s24_raw, s24_mag;
  logic [31:0] s32_raw, s32_mag;
  logic [7:0]  f32_exp;
  logic [22:0] f32_frac;
  logic [10:0] f64_exp;
  logic [51:0] f64_frac;
  logic [23:0] f64_q;
  logic [28:0] f64_rem;
  logic        f64_up;
  logic [24:0] f64_sig;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // integer magnitudes
  assign u8_byte = sample_bytes_i[7:0];
  assign u8_mag  = u8_byte[7] ? {1'b0, u8_byte[6:0]} : 8'd128 - u8_byte;
  assign s24_raw = sample_bytes_i[23:0];
  assign s24_mag = s24_raw[23] ? (~s24_raw + 24'd1) : s24_raw;
  assign s32_raw = sample_bytes_i[31:0];
  assign s32_mag = s32_raw[31] ? (~s32_raw + 32'd1) : s32_raw;

  // float fields; float64 significand narrowed to 24 bits, ties to even
  assign f32_exp  = sample_bytes_i[30:23];
  assign f32_frac = sample_bytes_i[22:0];
  assign f64_exp  = sample_bytes_i[62:52];
  assign f64_frac = sample_bytes_i[51:0];
  assign f64_q    = {1'b1, f64_frac[51:29]};
  assign f64_rem  = f64_frac[28:0];
  assign f64_up   = f64_rem[28] && ((f64_rem[27:0] != 28'd0) || f64_q[0]);
  assign f64_sig  = {1'b0, f64_q} + {24'b0, f64_up};

  // decode into sign, significand and alignment shift
  always_comb begin
    s1_d = '0;
    case (fmt_e'(fmt_q))
      FMT_U8: begin
        s1_d.side.neg = !u8_byte[7];
        s1_d.sig      = {24'b0, u8_mag};
        s1_d.shamt    = U8_SHAMT;
      end
      FMT_S16: begin
        s1_d.side.pass     = 1'b1;
        s1_d.side.pass_val = sample_bytes_i[15:0];
      end
      FMT_S24: begin
        s1_d.side.neg = s24_raw[23];
        s1_d.sig      = {8'b0, s24_mag};
        s1_d.shamt    = S24_SHAMT;
      end
      FMT_S32: begin
        s1_d.side.neg = s32_raw[31];
        s1_d.sig      = s32_mag;
        s1_d.shamt    = S32_SHAMT;
      end
      FMT_F32: begin
        s1_d.side.neg = sample_bytes_i[31];
        if (f32_exp == F32_EXP_SPECIAL) begin
          // nan gives zero, infinity clamps
          if (f32_frac == 23'd0) begin
            s1_d.sig   = SAT_SIG;
            s1_d.shamt = SAT_SHAMT;
          end
        end else if (f32_exp >= F32_EXP_ONE) begin
          s1_d.sig   = SAT_SIG;
          s1_d.shamt = SAT_SHAMT;
        end else if (f32_exp >= F32_EXP_MIN) begin
          s1_d.sig   = {8'b0, 1'b1, f32_frac};
          s1_d.shamt = 6'(f32_exp - F32_EXP_MIN);
        end
      end
      FMT_F64: begin
        s1_d.side.neg = sample_bytes_i[63];
        if (f64_exp == F64_EXP_SPECIAL) begin
          if (f64_frac == 52'd0) begin
            s1_d.sig   = SAT_SIG;
            s1_d.shamt = SAT_SHAMT;
          end
        end else if (f64_exp >= F64_EXP_ONE) begin
          s1_d.sig   = SAT_SIG;
          s1_d.shamt = SAT_SHAMT;
        end else if (f64_exp >= F64_EXP_MIN) begin
          // a rounding carry to 2^24 aligns the same as 2^23 one step up
          s1_d.sig   = {7'b0, f64_sig};
          s1_d.shamt = 6'(f64_exp - F64_EXP_MIN);
        end
      end
      default: begin
        s1_d = '0;
      end
    endcase
  end

  // decode stage register
  assign s1_rdy     = !s1_vld_q || !norm_stall;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // rounding and alignment
  a2p_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_vld_q),
    .in_stall_o  (norm_stall),
    .in_dec_i    (s1_q),
    .out_valid_o (norm_vld),
    .out_stall_i (quant_stall),
    .out_mag_o   (norm_mag)
  );

  // scaling and integer rounding
  a2p_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_vld),
    .in_stall_o  (quant_stall),
    .in_mag_i    (norm_mag),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pcm_o   (pcm)
  );

  assign pcm_sample_o = $signed(pcm);

  // an empty output means the whole pipe can take a transaction
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("audio_sample_to_pcm16_unit: stall with empty output");

  // a blocked decode stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_rdy) |=> (s1_vld_q && $stable(s1_q.sig) && $stable(s1_q.shamt)))
    else $error("audio_sample_to_pcm16_unit: decode stage lost its data");

  // only s32 significands may carry more than 25 bits
  a_sig_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && (s1_q.shamt != S32_SHAMT)) |-> (s1_q.sig[31:25] == 7'd0))
    else $error("audio_sample_to_pcm16_unit: significand too wide");

endmodule
